>>> rtl/core/ncle_pkg.sv
`timescale 1ns / 1ps
// ncle_pkg: event codes, register addresses, state and result types for the noise channel
// no dependencies

package ncle_pkg;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_FREQ_TICK = 3'd2,
    CMD_LEN_TICK  = 3'd3,
    CMD_ENV_TICK  = 3'd4
  } cmd_e;

  localparam logic [15:0] ADDR_LEN  = 16'hFF20;
  localparam logic [15:0] ADDR_ENV  = 16'hFF21;
  localparam logic [15:0] ADDR_POLY = 16'hFF22;
  localparam logic [15:0] ADDR_CTRL = 16'hFF23;

  localparam logic [7:0]  CTRL_READ_MASK = 8'hBF;
  localparam logic [7:0]  UNMAPPED_DATA  = 8'hFF;
  localparam logic [6:0]  LEN_FULL       = 7'd64;
  localparam logic [14:0] LFSR_SEED      = 15'h7FFF;

  localparam int unsigned TIMER_W = 22;

  typedef struct packed {
    logic [7:0]         envelope_reg;
    logic [7:0]         poly_reg;
    logic [7:0]         control_reg;
    logic               enabled;
    logic [TIMER_W-1:0] freq_timer;
    logic [6:0]         length_count;
    logic [2:0]         env_timer;
    logic [3:0]         level;
    logic [14:0]        shift_reg;
  } state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;
  } result_t;

  // timer reload: 8 for code 0, else 16*code, shifted by the clock shift
  function automatic logic [TIMER_W-1:0] noise_period(input logic [7:0] poly);
    logic [TIMER_W-1:0] base;
    base = (poly[2:0] == 3'd0) ? TIMER_W'(8) : TIMER_W'({poly[2:0], 4'b0000});
    return base << poly[7:4];
  endfunction

  // dac is on when envelope bits 7..3 are not all zero
  function automatic logic dac_on(input logic [7:0] env);
    return env[7:3] != 5'd0;
  endfunction

endpackage

>>> rtl/core/ncle_in_if.sv
`timescale 1ns / 1ps
// ncle_in_if: event channel (valid, ready, cmd, address, write_data)
// depends on nothing

interface ncle_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output cmd, output address, output write_data, input ready);
  modport sink   (input valid, input cmd, input address, input write_data, output ready);
endinterface

>>> rtl/core/ncle_out_if.sv
`timescale 1ns / 1ps
// ncle_out_if: result channel (valid, ready, read_data, sample, channel_on)
// depends on nothing

interface ncle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] sample;
  logic       channel_on;

  modport source (output valid, output read_data, output sample, output channel_on, input ready);
  modport sink   (input valid, input read_data, input sample, input channel_on, output ready);
endinterface

>>> rtl/core/ncle_core.sv
`timescale 1ns / 1ps
// ncle_core: channel state registers and the single-pass event update
// depends on ncle_pkg

module ncle_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         write_data_i,
  output ncle_pkg::result_t  result_o
);

  ncle_pkg::state_t state_q, state_d;
  logic [7:0]       rd_data;
  logic [ncle_pkg::TIMER_W-1:0] freq_dec;
  logic [2:0]       env_dec;
  logic             fb;
  logic [14:0]      lfsr_next;

  assign freq_dec = state_q.freq_timer - ncle_pkg::TIMER_W'(1);
  assign env_dec  = state_q.env_timer - 3'd1;
  assign fb       = state_q.shift_reg[0] ^ state_q.shift_reg[1];

  always_comb begin
    lfsr_next = {fb, state_q.shift_reg[14:1]};
    if (state_q.poly_reg[3]) begin
      lfsr_next[6] = fb;
    end
  end

  always_comb begin
    state_d = state_q;
    rd_data = 8'h00;
    if (en_i) begin
      unique case (cmd_i)
        ncle_pkg::CMD_READ: begin
          priority if (address_i == ncle_pkg::ADDR_ENV) begin
            rd_data = state_q.envelope_reg;
          end else if (address_i == ncle_pkg::ADDR_POLY) begin
            rd_data = state_q.poly_reg;
          end else if (address_i == ncle_pkg::ADDR_CTRL) begin
            rd_data = state_q.control_reg | ncle_pkg::CTRL_READ_MASK;
          end else begin
            rd_data = ncle_pkg::UNMAPPED_DATA;
          end
        end
        ncle_pkg::CMD_WRITE: begin
          priority if (address_i == ncle_pkg::ADDR_LEN) begin
            state_d.length_count = ncle_pkg::LEN_FULL - {1'b0, write_data_i[5:0]};
          end else if (address_i == ncle_pkg::ADDR_ENV) begin
            state_d.envelope_reg = write_data_i;
            if (!ncle_pkg::dac_on(write_data_i)) begin
              state_d.enabled = 1'b0;
            end
          end else if (address_i == ncle_pkg::ADDR_POLY) begin
            state_d.poly_reg = write_data_i;
          end else if (address_i == ncle_pkg::ADDR_CTRL) begin
            state_d.control_reg = write_data_i;
            if (write_data_i[7]) begin
              if (ncle_pkg::dac_on(state_q.envelope_reg)) begin
                state_d.enabled = 1'b1;
              end
              if (state_q.length_count == 7'd0) begin
                state_d.length_count = ncle_pkg::LEN_FULL;
              end
              state_d.env_timer  = state_q.envelope_reg[2:0];
              state_d.level      = state_q.envelope_reg[7:4];
              state_d.shift_reg  = ncle_pkg::LFSR_SEED;
              state_d.freq_timer = ncle_pkg::noise_period(state_q.poly_reg);
            end
          end else begin
          end
        end
        ncle_pkg::CMD_FREQ_TICK: begin
          if (state_q.freq_timer != '0) begin
            if (freq_dec == '0) begin
              state_d.freq_timer = ncle_pkg::noise_period(state_q.poly_reg);
              state_d.shift_reg  = lfsr_next;
            end else begin
              state_d.freq_timer = freq_dec;
            end
          end
        end
        ncle_pkg::CMD_LEN_TICK: begin
          if (state_q.control_reg[6] && state_q.length_count != 7'd0) begin
            state_d.length_count = state_q.length_count - 7'd1;
            if (state_q.length_count == 7'd1) begin
              state_d.enabled = 1'b0;
            end
          end
        end
        ncle_pkg::CMD_ENV_TICK: begin
          if (state_q.envelope_reg[2:0] != 3'd0 && state_q.env_timer != 3'd0) begin
            if (env_dec == 3'd0) begin
              state_d.env_timer = state_q.envelope_reg[2:0];
              if (state_q.envelope_reg[3]) begin
                if (state_q.level != 4'hF) begin
                  state_d.level = state_q.level + 4'd1;
                end
              end else if (state_q.level != 4'h0) begin
                state_d.level = state_q.level - 4'd1;
              end
            end else begin
              state_d.env_timer = env_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_o.read_data  = rd_data;
    result_o.channel_on = state_d.enabled;
    result_o.sample     = (state_d.enabled && ncle_pkg::dac_on(state_d.envelope_reg)
                           && !state_d.shift_reg[0]) ? state_d.level : 4'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{shift_reg: ncle_pkg::LFSR_SEED, default: '0};
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/noise_channel_lfsr_envelope_unit.sv
`timescale 1ns / 1ps
// noise_channel_lfsr_envelope_unit: top level, event handshake and result register
// depends on ncle_pkg, ncle_in_if, ncle_out_if, ncle_core
//
// usage:
// - in_i carries one event per transaction: bus read, bus write, frequency tick,
//   length tick or envelope tick (cmd), with address and write_data for bus accesses
// - out_o returns one transaction per event: read_data (0 unless a read), the
//   4-bit sample and channel_on, all as they stand after the event
// - the result is registered and becomes valid in the cycle after the event is accepted
// - throughput: one event per cycle while out_o.ready holds; the state update is a
//   single combinational pass from the channel registers into the result register
// - in_i.ready is high while the result register is empty or being taken, so a
//   stalled receiver holds the pending result and blocks only the next event
// - reset clears the channel registers, sets the shift register to all ones and
//   leaves the result register empty

module noise_channel_lfsr_envelope_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ncle_in_if.sink     in_i,
  ncle_out_if.source  out_o
);

  ncle_pkg::result_t result_d, result_q;
  logic              out_valid_q;
  logic              accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  ncle_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .cmd_i        (in_i.cmd),
    .address_i    (in_i.address),
    .write_data_i (in_i.write_data),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = result_q.read_data;
  assign out_o.sample     = result_q.sample;
  assign out_o.channel_on = result_q.channel_on;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted transaction produced no result");

  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.cmd != ncle_pkg::CMD_READ) |=> out_o.read_data == 8'h00)
    else $error("nonzero read data for a non-read transaction");

  a_sample_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.sample != 4'h0) |-> out_o.channel_on)
    else $error("sample output while channel is off");

endmodule
